FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KWS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked on the next rising edge after the antecedent.
`define KWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/kwsdfa_pkg.sv
`timescale 1ns / 1ps

package kwsdfa_pkg;

  localparam int STATE_W    = 5;
  localparam int KIND_COUNT = 6;

  typedef logic [STATE_W-1:0] dfa_state_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_WEB       = 3'd1,
    KIND_WEBMASTER = 3'd2,
    KIND_WEBSITE   = 3'd3,
    KIND_EBAY      = 3'd4,
    KIND_PAGEWEB   = 3'd5,
    KIND_NET       = 3'd6
  } kind_t;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_B  = 8'h62;
  localparam logic [7:0] CH_E  = 8'h65;
  localparam logic [7:0] CH_G  = 8'h67;
  localparam logic [7:0] CH_I  = 8'h69;
  localparam logic [7:0] CH_M  = 8'h6D;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_P  = 8'h70;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_W  = 8'h77;
  localparam logic [7:0] CH_Y  = 8'h79;

  // Start and fallback states, then the accepting states of the automaton, one per keyword, and the highest state.
  localparam dfa_state_t ST_START     = 5'd0;
  localparam dfa_state_t ST_OTHER     = 5'd1;
  localparam dfa_state_t ST_WEB       = 5'd4;
  localparam dfa_state_t ST_WEBMASTER = 5'd10;
  localparam dfa_state_t ST_WEBSITE   = 5'd14;
  localparam dfa_state_t ST_EBAY      = 5'd18;
  localparam dfa_state_t ST_PAGEWEB   = 5'd25;
  localparam dfa_state_t ST_NET       = 5'd28;
  localparam dfa_state_t ST_LAST      = 5'd28;

  // Transition table of the keyword automaton.
  function automatic dfa_state_t dfa_next(input dfa_state_t s, input logic [7:0] c);
    dfa_state_t n;
    n = ST_OTHER;
    unique case (c)
      CH_A: begin
        if (s == 5'd4 || s == 5'd16 || s == 5'd25) n = 5'd17;
        else if (s == 5'd5) n = 5'd6;
        else if (s == 5'd19) n = 5'd20;
      end
      CH_B: begin
        if (s == 5'd3) n = 5'd4;
        else if (s == 5'd9 || s == 5'd14 || s == 5'd15 || s == 5'd22 || s == 5'd27) n = 5'd16;
        else if (s == 5'd24) n = 5'd25;
      end
      CH_E: begin
        n = 5'd15;
        if (s == 5'd2) n = 5'd3;
        else if (s == 5'd8) n = 5'd9;
        else if (s == 5'd13) n = 5'd14;
        else if (s == 5'd21) n = 5'd22;
        else if (s == 5'd23) n = 5'd24;
        else if (s == 5'd26) n = 5'd27;
      end
      CH_G: if (s == 5'd20) n = 5'd21;
      CH_I: if (s == 5'd11) n = 5'd12;
      CH_M: if (s == 5'd4 || s == 5'd25) n = 5'd5;
      CH_N: n = 5'd26;
      CH_P: n = 5'd19;
      CH_R: if (s == 5'd9) n = 5'd10;
      CH_S: begin
        if (s == 5'd4 || s == 5'd25) n = 5'd11;
        else if (s == 5'd6) n = 5'd7;
      end
      CH_T: begin
        if (s == 5'd7) n = 5'd8;
        else if (s == 5'd12) n = 5'd13;
        else if (s == 5'd27) n = 5'd28;
      end
      CH_W: n = (s == 5'd22) ? 5'd23 : 5'd2;
      CH_Y: if (s == 5'd17) n = 5'd18;
      default: n = ST_OTHER;
    endcase
    return n;
  endfunction

  function automatic kind_t kind_of(input dfa_state_t s);
    kind_t k;
    unique case (s)
      ST_WEB:       k = KIND_WEB;
      ST_WEBMASTER: k = KIND_WEBMASTER;
      ST_WEBSITE:   k = KIND_WEBSITE;
      ST_EBAY:      k = KIND_EBAY;
      ST_PAGEWEB:   k = KIND_PAGEWEB;
      ST_NET:       k = KIND_NET;
      default:      k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] kw_length(input kind_t k);
    logic [3:0] len;
    unique case (k)
      KIND_WEB:       len = 4'd3;
      KIND_WEBMASTER: len = 4'd9;
      KIND_WEBSITE:   len = 4'd7;
      KIND_EBAY:      len = 4'd4;
      KIND_PAGEWEB:   len = 4'd7;
      KIND_NET:       len = 4'd3;
      default:        len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/keyword_scanner_dfa_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Keyword scanner: every text byte taken on the s_ stream yields exactly one result on the
// m_ stream, in order. The block runs a 29-state automaton that spots web, webmaster,
// website, ebay, pageweb and net, overlaps included, and reports the state after the byte,
// the keyword that ends on it, the line and start/end column, the running count of that
// keyword and the running count of web (a pageweb also counts as a web). A line feed (0x0A)
// leaves the automaton alone, advances the line and clears the column, so a keyword may
// straddle lines and then has a negative start column. Line, column and counts saturate.
// Throughput is one byte per clock while s_tready is high; the automaton step, the
// saturating counter updates and the count select all sit between the state registers and
// the result register. A two-entry output buffer (result register plus skid register)
// keeps s_tready a registered signal and lets one more request in while a result waits.

module keyword_scanner_dfa_unit
  import kwsdfa_pkg::*;
#(
  parameter int COLUMN_WIDTH = 12,
  parameter int LINE_WIDTH   = 20,
  parameter int COUNT_WIDTH  = 32,
  localparam int START_W  = COLUMN_WIDTH + 1,
  localparam int OUT_FW   = STATE_W + 3 + LINE_WIDTH + START_W + COLUMN_WIDTH
                            + 2 * COUNT_WIDTH,
  localparam int OUT_TW   = ((OUT_FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // char_code
  output logic              m_tvalid,
  input  logic              m_tready,
  // next_state, match_kind, line_number, start_column, end_column, kind_total,
  // web_total, then zero fill
  output logic [OUT_TW-1:0] m_tdata
);

  // Scanner state.
  dfa_state_t              dfa_state;
  logic [LINE_WIDTH-1:0]   line_cnt;
  logic [COLUMN_WIDTH-1:0] col_cnt;
  logic [COUNT_WIDTH-1:0]  kw_count [KIND_COUNT];

  dfa_state_t              dfa_state_next;
  logic [LINE_WIDTH-1:0]   line_cnt_next;
  logic [COLUMN_WIDTH-1:0] col_cnt_next;
  logic [COUNT_WIDTH-1:0]  kw_count_next [KIND_COUNT];

  // Output buffer.
  logic              out_valid;
  logic [OUT_TW-1:0] out_data;
  logic              skid_valid;
  logic [OUT_TW-1:0] skid_data;

  logic              accept;
  logic              is_lf;
  kind_t             kind;
  logic [START_W-1:0]     start_col;
  logic [COUNT_WIDTH-1:0] kind_total;
  logic [OUT_TW-1:0]      result;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign is_lf    = (s_tdata == CH_LF);

  // One byte of work: automaton step, counter updates and result assembly.
  always_comb begin
    dfa_state_next = dfa_state;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    kind           = KIND_NONE;
    start_col      = '0;
    kind_total     = '0;
    for (int i = 0; i < KIND_COUNT; i++) begin
      kw_count_next[i] = kw_count[i];
    end

    if (is_lf) begin
      if (!(&line_cnt)) begin
        line_cnt_next = line_cnt + LINE_WIDTH'(1);
      end
      col_cnt_next = '0;
    end else begin
      dfa_state_next = dfa_next(dfa_state, s_tdata);
      kind           = kind_of(dfa_state_next);
      // A pageweb also ends a web, so the web counter moves with it.
      for (int i = 0; i < KIND_COUNT; i++) begin
        if (((kind == kind_t'(3'(i + 1))) || (i == 0 && kind == KIND_PAGEWEB)) &&
            !(&kw_count[i])) begin
          kw_count_next[i] = kw_count[i] + COUNT_WIDTH'(1);
        end
      end
      if (kind != KIND_NONE) begin
        start_col = ({1'b0, col_cnt} + START_W'(1)) - START_W'(kw_length(kind));
      end
      if (!(&col_cnt)) begin
        col_cnt_next = col_cnt + COLUMN_WIDTH'(1);
      end
    end

    case (kind)
      KIND_WEB:       kind_total = kw_count_next[0];
      KIND_WEBMASTER: kind_total = kw_count_next[1];
      KIND_WEBSITE:   kind_total = kw_count_next[2];
      KIND_EBAY:      kind_total = kw_count_next[3];
      KIND_PAGEWEB:   kind_total = kw_count_next[4];
      KIND_NET:       kind_total = kw_count_next[5];
      default:        kind_total = '0;
    endcase

    result = '0;
    result[OUT_FW-1:0] = {kw_count_next[0], kind_total, col_cnt, start_col, line_cnt,
                          kind, dfa_state_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state <= ST_START;
      line_cnt  <= '0;
      col_cnt   <= '0;
      for (int i = 0; i < KIND_COUNT; i++) begin
        kw_count[i] <= '0;
      end
    end else if (accept) begin
      dfa_state <= dfa_state_next;
      line_cnt  <= line_cnt_next;
      col_cnt   <= col_cnt_next;
      for (int i = 0; i < KIND_COUNT; i++) begin
        kw_count[i] <= kw_count_next[i];
      end
    end
  end

  // The skid register only fills while the result register is stalled, and it drains
  // into the result register first, so results leave in request order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  `KWS_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `KWS_ASSERT_SAME(a_state_reachable, clk, rst, 1'b1, dfa_state <= ST_LAST)
  `KWS_ASSERT_NEXT(a_lf_clears_col, clk, rst, accept && is_lf, col_cnt == '0)
  `KWS_ASSERT_SAME(a_match_counted, clk, rst, accept && kind != KIND_NONE, kind_total != '0)

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

// Checks the keyword scanner against a behavioral copy of its automaton and counters.
// A short directed run comes first. It uses extreme bytes, net, ebay, a pageweb
// that also counts as a web, and a webmaster split by a line feed so that its start
// column goes to -8. Random text follows, mostly built from the keywords, with line
// feeds inside words so that matches straddle lines. Every accepted request is
// predicted, and every accepted result is compared field by field with the oldest
// prediction.

module tb;
  import kwsdfa_pkg::*;

  // One result, with the last field (state) in the lowest bits as on m_tdata.
  typedef struct packed {
    logic [31:0]        web_total;
    logic [31:0]        kind_total;
    logic [11:0]        end_col;
    logic signed [12:0] start_col;
    logic [19:0]        line;
    kind_t              kind;
    dfa_state_t         state;
  } scan_result_t;

  localparam int RES_W       = $bits(scan_result_t);
  localparam int TDATA_W     = ((RES_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct {
    logic [7:0]   ch;
    bit           typed;
    scan_result_t want;
  } dir_row_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic [7:0]         s_tdata  = 8'h00;
  logic               s_tready;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;

  // Behavioral copy of the scanner state.
  dfa_state_t  scan_state;
  logic [19:0] scan_line;
  logic [11:0] scan_col;
  logic [31:0] kw_count [1:6];

  scan_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  int           mismatch_count = 0;
  bit           gaps_on   = 1'b1;
  bit           stalls_on = 1'b1;

  string keyword_text [12] = '{"web", "webmaster", "website", "ebay", "pageweb", "net",
                               "pagewebsite", "pagewebmaster", "webay", "neebay",
                               "websiteebay", "wwebnet"};
  string letter_set = "abegimnprstwy";

  keyword_scanner_dfa_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Automaton transition, written out per byte.
  function automatic dfa_state_t next_scan_state(input dfa_state_t s, input logic [7:0] ch);
    dfa_state_t n;
    n = ST_OTHER;
    case (ch)
      CH_A: begin
        if (s == 5'd4 || s == 5'd16 || s == 5'd25) n = 5'd17;
        else if (s == 5'd5) n = 5'd6;
        else if (s == 5'd19) n = 5'd20;
      end
      CH_B: begin
        if (s == 5'd3) n = 5'd4;
        else if (s == 5'd9 || s == 5'd14 || s == 5'd15 || s == 5'd22 || s == 5'd27)
          n = 5'd16;
        else if (s == 5'd24) n = 5'd25;
      end
      CH_E: begin
        case (s)
          5'd2:    n = 5'd3;
          5'd8:    n = 5'd9;
          5'd13:   n = 5'd14;
          5'd21:   n = 5'd22;
          5'd23:   n = 5'd24;
          5'd26:   n = 5'd27;
          default: n = 5'd15;
        endcase
      end
      CH_G: if (s == 5'd20) n = 5'd21;
      CH_I: if (s == 5'd11) n = 5'd12;
      CH_M: if (s == 5'd4 || s == 5'd25) n = 5'd5;
      CH_N: n = 5'd26;
      CH_P: n = 5'd19;
      CH_R: if (s == 5'd9) n = 5'd10;
      CH_S: begin
        if (s == 5'd4 || s == 5'd25) n = 5'd11;
        else if (s == 5'd6) n = 5'd7;
      end
      CH_T: begin
        if (s == 5'd7) n = 5'd8;
        else if (s == 5'd12) n = 5'd13;
        else if (s == 5'd27) n = 5'd28;
      end
      CH_W: n = (s == 5'd22) ? 5'd23 : 5'd2;
      CH_Y: if (s == 5'd17) n = 5'd18;
      default: n = ST_OTHER;
    endcase
    return n;
  endfunction

  function automatic kind_t accepted_kind(input dfa_state_t s);
    case (s)
      ST_WEB:       return KIND_WEB;
      ST_WEBMASTER: return KIND_WEBMASTER;
      ST_WEBSITE:   return KIND_WEBSITE;
      ST_EBAY:      return KIND_EBAY;
      ST_PAGEWEB:   return KIND_PAGEWEB;
      ST_NET:       return KIND_NET;
      default:      return KIND_NONE;
    endcase
  endfunction

  function automatic logic [12:0] keyword_len(input kind_t k);
    case (k)
      KIND_WEBMASTER:             return 13'd9;
      KIND_WEBSITE, KIND_PAGEWEB: return 13'd7;
      KIND_EBAY:                  return 13'd4;
      KIND_WEB, KIND_NET:         return 13'd3;
      default:                    return 13'd0;
    endcase
  endfunction

  function automatic scan_result_t typed_result(input dfa_state_t state, input kind_t kind,
                                                input logic [19:0] line,
                                                input logic signed [12:0] start_col,
                                                input logic [11:0] end_col,
                                                input logic [31:0] kind_total,
                                                input logic [31:0] web_total);
    scan_result_t r;
    r.state      = state;
    r.kind       = kind;
    r.line       = line;
    r.start_col  = start_col;
    r.end_col    = end_col;
    r.kind_total = kind_total;
    r.web_total  = web_total;
    return r;
  endfunction

  // Advances the copied state by one byte and returns the result it should produce.
  task automatic predict_scan(input logic [7:0] ch, output scan_result_t r);
    kind_t k;
    r         = '0;
    r.kind    = KIND_NONE;
    r.line    = scan_line;
    r.end_col = scan_col;
    if (ch == CH_LF) begin
      // A line feed bypasses the automaton, so a keyword may continue on the next line.
      if (scan_line != '1) scan_line++;
      scan_col = '0;
    end else begin
      scan_state = next_scan_state(scan_state, ch);
      k = accepted_kind(scan_state);
      if (k != KIND_NONE) begin
        if (kw_count[int'(k)] != '1) kw_count[int'(k)]++;
        if (k == KIND_PAGEWEB && kw_count[int'(KIND_WEB)] != '1) kw_count[int'(KIND_WEB)]++;
        r.kind       = k;
        r.kind_total = kw_count[int'(k)];
        r.start_col  = {1'b0, scan_col} + 13'd1 - keyword_len(k);
      end
      if (scan_col != '1) scan_col++;
    end
    r.state     = scan_state;
    r.web_total = kw_count[int'(KIND_WEB)];
  endtask

  task automatic add_row(input logic [7:0] ch, input bit typed = 1'b0,
                         input scan_result_t want = '0);
    dir_row_t row;
    row.ch    = ch;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Entered just after a falling edge. Returns just after the falling edge that follows
  // the acceptance of the request.
  task automatic send_char(input logic [7:0] ch, input bit typed, input scan_result_t want);
    scan_result_t predicted;
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_scan(ch, predicted);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Random text: mostly whole or broken keywords, some keyword letters and some raw bytes.
  // Line feeds fall inside words so that matches straddle lines.
  task automatic scan_burst(input int n_items, input bit allow_lf);
    logic [7:0] frag [$];
    string      word;
    int         sent;
    int         pick;
    int         cut;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      frag.delete();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        word = keyword_text[$urandom_range(0, 11)];
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, word.len()) : word.len();
        for (int i = 0; i < cut; i++) frag.push_back(word[i]);
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 4)) frag.push_back(letter_set[$urandom_range(0, 12)]);
      end else begin
        repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom_range(0, 255)));
      end
      foreach (frag[i]) begin
        ch = frag[i];
        if (allow_lf && $urandom_range(0, 99) < 4) begin
          send_char(CH_LF, 1'b0, '0);
          sent++;
        end
        if (!allow_lf && ch == CH_LF) ch = CH_SPACE;
        send_char(ch, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Entered just after a falling edge; the sender goes idle until every result is back.
  task automatic wait_drained;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin
    m_tready <= stalls_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
  end

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RES_W-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got %0h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_state", want.state, got.state);
        check_field("match_kind", want.kind, got.kind);
        check_field("line_number", want.line, got.line);
        check_field("start_column", {19'd0, want.start_col}, {19'd0, got.start_col});
        check_field("end_column", want.end_col, got.end_col);
        check_field("kind_total", want.kind_total, got.kind_total);
        check_field("web_total", want.web_total, got.web_total);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    scan_state = ST_START;
    scan_line  = '0;
    scan_col   = '0;
    foreach (kw_count[i]) kw_count[i] = '0;

    // Extreme bytes after reset, then net, pageweb (which also bumps web), and a
    // webmaster split by a line feed whose start column lands at -8. An ebay
    // follows right after it.
    add_row(8'h00, 1'b1, typed_result(ST_OTHER, KIND_NONE, 20'd0, 13'sd0, 12'd0, 0, 0));
    add_row(8'hFF, 1'b1, typed_result(ST_OTHER, KIND_NONE, 20'd0, 13'sd0, 12'd1, 0, 0));
    add_row(CH_N);
    add_row(CH_E);
    add_row(CH_T, 1'b1, typed_result(ST_NET, KIND_NET, 20'd0, 13'sd2, 12'd4, 1, 0));
    add_row(CH_P);
    add_row(CH_A);
    add_row(CH_G);
    add_row(CH_E);
    add_row(CH_W);
    add_row(CH_E);
    add_row(CH_B);
    add_row(CH_M);
    add_row(CH_A);
    add_row(CH_S);
    add_row(CH_T);
    add_row(CH_E);
    add_row(CH_LF, 1'b1, typed_result(5'd9, KIND_NONE, 20'd0, 13'sd0, 12'd17, 0, 1));
    add_row(CH_R, 1'b1,
            typed_result(ST_WEBMASTER, KIND_WEBMASTER, 20'd1, -13'sd8, 12'd0, 1, 1));
    add_row(CH_E);
    add_row(CH_B);
    add_row(CH_A);
    add_row(CH_Y);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    scan_burst(400, 1'b1);

    // Full throughput with no bubbles on either side.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    scan_burst(250, 1'b1);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    wait_drained();

    scan_burst(250, 1'b1);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
